// ===== rtl/lsystem_3d_turtle_interpreter_unit_assert.svh =====
// Assertion macros shared by the turtle interpreter RTL.
`ifndef LSYSTEM_3D_TURTLE_INTERPRETER_UNIT_ASSERT_SVH
`define LSYSTEM_3D_TURTLE_INTERPRETER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define LTTI_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LTTI_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ltti_pkg.sv =====
// Package of the turtle interpreter: widths, symbol codes, register indexes and status codes.
`timescale 1ns / 1ps

package ltti_pkg;

   localparam int unsigned LTTI_STACK_DEPTH = 16;
   localparam int unsigned LTTI_FRAC_BITS   = 16;

   localparam int unsigned SYM_W      = 8;
   localparam int unsigned POS_W      = 32;
   localparam int unsigned COEF_W     = 18;
   localparam int unsigned MASK_W     = 64;
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 64;
   localparam int unsigned REG_LSB    = 3;

   localparam logic signed [COEF_W-1:0] COS_RESET = COEF_W'(65536);
   localparam logic signed [COEF_W-1:0] SIN_RESET = '0;

   localparam logic [SYM_W-1:0] SYM_PLUS        = 8'd43;
   localparam logic [SYM_W-1:0] SYM_MINUS       = 8'd45;
   localparam logic [SYM_W-1:0] SYM_PITCH_UP    = 8'd94;
   localparam logic [SYM_W-1:0] SYM_PITCH_DOWN  = 8'd38;
   localparam logic [SYM_W-1:0] SYM_ROLL_LEFT   = 8'd92;
   localparam logic [SYM_W-1:0] SYM_ROLL_RIGHT  = 8'd47;
   localparam logic [SYM_W-1:0] SYM_TURN_AROUND = 8'd124;
   localparam logic [SYM_W-1:0] SYM_PUSH        = 8'd40;
   localparam logic [SYM_W-1:0] SYM_POP         = 8'd41;

   // Symbols whose upper two bits are this value may draw.
   localparam logic [1:0] DRAW_BANK = 2'b01;

   typedef enum logic [1:0] {
      ST_DRAWN     = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_COS_ANGLE = 2'd0,
      REG_SIN_ANGLE = 2'd1,
      REG_DRAW_MASK = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      CMD_ROTATE,
      CMD_TURN,
      CMD_PUSH,
      CMD_POP,
      CMD_MOVE
   } cmd_type;

   typedef enum logic [1:0] {
      PAIR_HL,
      PAIR_HU,
      PAIR_LU
   } pair_type;

endpackage

// ===== rtl/ltti_req_if.sv =====
// Symbol channel of the turtle interpreter.
`timescale 1ns / 1ps

interface ltti_req_if
   import ltti_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] symbol;
   logic             restart;

   modport source (output valid, output symbol, output restart, input ready);
   modport sink   (input valid, input symbol, input restart, output ready);
endinterface

// ===== rtl/ltti_rsp_if.sv =====
// Segment and status channel of the turtle interpreter.
`timescale 1ns / 1ps

interface ltti_rsp_if
   import ltti_pkg::*;
();
   logic                    valid;
   logic                    ready;
   status_type              status;
   logic signed [POS_W-1:0] start_x;
   logic signed [POS_W-1:0] start_y;
   logic signed [POS_W-1:0] start_z;
   logic signed [POS_W-1:0] end_x;
   logic signed [POS_W-1:0] end_y;
   logic signed [POS_W-1:0] end_z;

   modport source (output valid, output status, output start_x, output start_y,
                   output start_z, output end_x, output end_y, output end_z,
                   input ready);
   modport sink   (input valid, input status, input start_x, input start_y,
                   input start_z, input end_x, input end_y, input end_z,
                   output ready);
endinterface

// ===== rtl/ltti_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ltti_ram #(
   parameter int unsigned WIDTH  = 8,
   parameter int unsigned DEPTH  = 16,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lsystem_3d_turtle_interpreter_unit.sv =====
// Top level of the 3D turtle interpreter: turtle state, rotations, stack and result register.
// The turtle update is one registered pass: a symbol's result is on rsp_if in the next cycle.
// Throughput: one symbol per cycle, held off while a stalled result fills the register.
// Reset (synchronous, active high) homes the turtle, empties the stack, restores registers.
`timescale 1ns / 1ps

module lsystem_3d_turtle_interpreter_unit
   import ltti_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = LTTI_STACK_DEPTH,
   parameter int unsigned FRAC_BITS   = LTTI_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   ltti_req_if.sink              req_if,
   ltti_rsp_if.source            rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

`include "lsystem_3d_turtle_interpreter_unit_assert.svh"

   // Direction components are Q1.FRAC_BITS with one guard bit, so two integer bits.
   localparam int unsigned DIR_W   = FRAC_BITS + 2;
   localparam int unsigned PROD_W  = DIR_W + COEF_W;
   localparam int unsigned SUM_W   = PROD_W + 1;
   localparam int unsigned LVL_W   = $clog2(STACK_DEPTH + 1);
   localparam int unsigned ADDR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int unsigned ENTRY_W = 3 * POS_W + 9 * DIR_W;
   localparam int unsigned AXIS_W  = 3 * DIR_W;

   localparam logic signed [DIR_W-1:0] DIR_ONE = DIR_W'(1) << FRAC_BITS;
   localparam logic signed [SUM_W-1:0] DIR_MAX = (SUM_W'(1) << (DIR_W - 1)) - SUM_W'(1);
   localparam logic signed [SUM_W-1:0] DIR_MIN = ~DIR_MAX;
   localparam logic signed [SUM_W-1:0] RND     = SUM_W'(1) << (FRAC_BITS - 1);
   localparam logic [LVL_W-1:0]        LVL_FULL = LVL_W'(STACK_DEPTH);

   // Round a product sum to the nearest step (ties upwards) and clamp to the direction range.
   function automatic logic signed [DIR_W-1:0] round_dir(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] t;
      t = (v + RND) >>> FRAC_BITS;
      if (t > DIR_MAX) begin
         t = DIR_MAX;
      end else if (t < DIR_MIN) begin
         t = DIR_MIN;
      end
      return DIR_W'(t);
   endfunction

   // Negation clamps the single value that has no positive counterpart.
   function automatic logic signed [DIR_W-1:0] neg_dir(input logic signed [DIR_W-1:0] v);
      logic signed [DIR_W-1:0] r;
      if (v == DIR_W'(DIR_MIN)) begin
         r = DIR_W'(DIR_MAX);
      end else begin
         r = -v;
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------------------------
   // Configuration registers. The angle is given as its cosine and sine, so the rotation is
   // four multiplies per component; the draw mask selects which letters emit segments.
   // ------------------------------------------------------------------------------------------
   logic signed [COEF_W-1:0] cos_ff, cos_in;
   logic signed [COEF_W-1:0] sin_ff, sin_in;
   logic [MASK_W-1:0]        mask_ff, mask_in;
   logic                     csr_wr;
   reg_index_type            csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = reg_index_type'(csr_paddr[CSR_ADDR_W-1:REG_LSB]);

   always_comb begin
      cos_in     = cos_ff;
      sin_in     = sin_ff;
      mask_in    = mask_ff;
      csr_prdata = '0;
      unique case (csr_idx)
         REG_COS_ANGLE: begin
            csr_prdata = CSR_DATA_W'(cos_ff);
            if (csr_wr) begin
               cos_in = csr_pwdata[COEF_W-1:0];
            end
         end
         REG_SIN_ANGLE: begin
            csr_prdata = CSR_DATA_W'(sin_ff);
            if (csr_wr) begin
               sin_in = csr_pwdata[COEF_W-1:0];
            end
         end
         REG_DRAW_MASK: begin
            csr_prdata = mask_ff;
            if (csr_wr) begin
               mask_in = csr_pwdata[MASK_W-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff  <= COS_RESET;
         sin_ff  <= SIN_RESET;
         mask_ff <= '0;
      end else begin
         cos_ff  <= cos_in;
         sin_ff  <= sin_in;
         mask_ff <= mask_in;
      end
   end

   // ------------------------------------------------------------------------------------------
   // Handshake. The result register decouples the two channels: a new symbol is taken whenever
   // the register is empty or its contents are being transferred in the same cycle.
   // ------------------------------------------------------------------------------------------
   logic rsp_valid_ff, rsp_valid_in;
   logic req_fire;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_fire     = req_if.valid && req_if.ready;

   // ------------------------------------------------------------------------------------------
   // Turtle state.
   // ------------------------------------------------------------------------------------------
   logic signed [POS_W-1:0] pos_ff [3];
   logic signed [POS_W-1:0] pos_in [3];
   logic signed [DIR_W-1:0] hd_ff  [3];
   logic signed [DIR_W-1:0] hd_in  [3];
   logic signed [DIR_W-1:0] lf_ff  [3];
   logic signed [DIR_W-1:0] lf_in  [3];
   logic signed [DIR_W-1:0] up_ff  [3];
   logic signed [DIR_W-1:0] up_in  [3];
   logic [LVL_W-1:0]        lvl_ff, lvl_in;

   // State as seen by the current symbol, after an optional restart.
   logic signed [POS_W-1:0] cur_pos [3];
   logic signed [DIR_W-1:0] cur_hd  [3];
   logic signed [DIR_W-1:0] cur_lf  [3];
   logic signed [DIR_W-1:0] cur_up  [3];
   logic [LVL_W-1:0]        cur_lvl;

   // ------------------------------------------------------------------------------------------
   // Stack. Entries live in a RAM whose read address always tracks the entry below the level
   // the next symbol will see, so its top is ready in the following cycle. A push writes the
   // very entry being read, and the RAM returns the old contents then, so the pushed data is
   // also kept for one cycle in a bypass register that takes precedence.
   // ------------------------------------------------------------------------------------------
   logic [ENTRY_W-1:0] wr_entry;
   logic [ENTRY_W-1:0] ram_rdata;
   logic [ENTRY_W-1:0] top_entry;
   logic [ENTRY_W-1:0] byp_data_ff;
   logic               byp_ff;
   logic               push_ok;
   logic [LVL_W-1:0]   lvl_look;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ADDR_W-1:0]  wr_addr;

   assign lvl_look  = req_fire ? lvl_in : lvl_ff;
   assign rd_addr   = ADDR_W'(lvl_look - LVL_W'(1));
   assign wr_addr   = ADDR_W'(cur_lvl);
   assign top_entry = byp_ff ? byp_data_ff : ram_rdata;

   ltti_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (push_ok),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // ------------------------------------------------------------------------------------------
   // Command decode and the shared rotation datapath. Only one pair of axes turns per symbol,
   // so one set of twelve multipliers serves all six rotation symbols.
   // ------------------------------------------------------------------------------------------
   cmd_type  cmd;
   pair_type pair;
   logic     rot_neg;
   logic     draws;

   logic signed [DIR_W-1:0]  a_op [3];
   logic signed [DIR_W-1:0]  b_op [3];
   logic signed [PROD_W-1:0] p_ac [3];
   logic signed [PROD_W-1:0] p_bs [3];
   logic signed [PROD_W-1:0] p_bc [3];
   logic signed [PROD_W-1:0] p_as [3];
   logic signed [SUM_W-1:0]  na_sum [3];
   logic signed [SUM_W-1:0]  nb_sum [3];
   logic signed [DIR_W-1:0]  na [3];
   logic signed [DIR_W-1:0]  nb [3];
   logic signed [POS_W:0]    mv_sum [3];
   logic signed [POS_W-1:0]  mv_pos [3];

   always_comb begin
      cmd     = CMD_MOVE;
      pair    = PAIR_HL;
      rot_neg = 1'b0;
      unique case (req_if.symbol)
         SYM_PLUS: begin
            cmd = CMD_ROTATE;
         end
         SYM_MINUS: begin
            cmd     = CMD_ROTATE;
            rot_neg = 1'b1;
         end
         SYM_PITCH_UP: begin
            cmd  = CMD_ROTATE;
            pair = PAIR_HU;
         end
         SYM_PITCH_DOWN: begin
            cmd     = CMD_ROTATE;
            pair    = PAIR_HU;
            rot_neg = 1'b1;
         end
         SYM_ROLL_LEFT: begin
            cmd     = CMD_ROTATE;
            pair    = PAIR_LU;
            rot_neg = 1'b1;
         end
         SYM_ROLL_RIGHT: begin
            cmd  = CMD_ROTATE;
            pair = PAIR_LU;
         end
         SYM_TURN_AROUND: begin
            cmd = CMD_TURN;
         end
         SYM_PUSH: begin
            cmd = CMD_PUSH;
         end
         SYM_POP: begin
            cmd = CMD_POP;
         end
         default: begin
            cmd = CMD_MOVE;
         end
      endcase
      // Only letters in the second quarter of the code space have a draw bit.
      draws = (cmd == CMD_MOVE) && (req_if.symbol[SYM_W-1:SYM_W-2] == DRAW_BANK)
              && mask_ff[req_if.symbol[SYM_W-3:0]];
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cur_pos[i] = req_if.restart ? '0 : pos_ff[i];
         cur_hd[i]  = req_if.restart ? ((i == 0) ? DIR_ONE : '0) : hd_ff[i];
         cur_lf[i]  = req_if.restart ? ((i == 1) ? DIR_ONE : '0) : lf_ff[i];
         cur_up[i]  = req_if.restart ? ((i == 2) ? DIR_ONE : '0) : up_ff[i];
      end
      cur_lvl = req_if.restart ? '0 : lvl_ff;
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         case (pair)
            PAIR_HL: begin
               a_op[i] = cur_hd[i];
               b_op[i] = cur_lf[i];
            end
            PAIR_HU: begin
               a_op[i] = cur_hd[i];
               b_op[i] = cur_up[i];
            end
            default: begin
               a_op[i] = cur_lf[i];
               b_op[i] = cur_up[i];
            end
         endcase
         p_ac[i] = PROD_W'(a_op[i]) * PROD_W'(cos_ff);
         p_bs[i] = PROD_W'(b_op[i]) * PROD_W'(sin_ff);
         p_bc[i] = PROD_W'(b_op[i]) * PROD_W'(cos_ff);
         p_as[i] = PROD_W'(a_op[i]) * PROD_W'(sin_ff);
         // A turn by the negative angle flips the sign of every sine term.
         if (rot_neg) begin
            na_sum[i] = SUM_W'(p_ac[i]) - SUM_W'(p_bs[i]);
            nb_sum[i] = SUM_W'(p_bc[i]) + SUM_W'(p_as[i]);
         end else begin
            na_sum[i] = SUM_W'(p_ac[i]) + SUM_W'(p_bs[i]);
            nb_sum[i] = SUM_W'(p_bc[i]) - SUM_W'(p_as[i]);
         end
         na[i] = round_dir(na_sum[i]);
         nb[i] = round_dir(nb_sum[i]);

         // A step adds the heading to the position and clamps to the 32-bit range.
         mv_sum[i] = (POS_W + 1)'(cur_pos[i]) + (POS_W + 1)'(cur_hd[i]);
         if (mv_sum[i][POS_W] != mv_sum[i][POS_W-1]) begin
            mv_pos[i] = mv_sum[i][POS_W] ? {1'b1, {(POS_W - 1){1'b0}}}
                                         : {1'b0, {(POS_W - 1){1'b1}}};
         end else begin
            mv_pos[i] = mv_sum[i][POS_W-1:0];
         end
      end
   end

   // Stack entry layout: positions, then heading, left and up components.
   always_comb begin
      wr_entry = '0;
      for (int i = 0; i < 3; i++) begin
         wr_entry[i * POS_W +: POS_W]                        = cur_pos[i];
         wr_entry[3 * POS_W + i * DIR_W +: DIR_W]            = cur_hd[i];
         wr_entry[3 * POS_W + AXIS_W + i * DIR_W +: DIR_W]   = cur_lf[i];
         wr_entry[3 * POS_W + 2*AXIS_W + i * DIR_W +: DIR_W] = cur_up[i];
      end
   end

   // ------------------------------------------------------------------------------------------
   // Next turtle state and the result. Stack errors leave the turtle untouched and report a
   // status with zero coordinates; a plain step reports only when its letter draws.
   // ------------------------------------------------------------------------------------------
   logic        res_valid;
   logic        ovf;
   logic        unf;
   status_type  res_status;

   assign ovf     = (cmd == CMD_PUSH) && (cur_lvl == LVL_FULL);
   assign unf     = (cmd == CMD_POP) && (cur_lvl == '0);
   assign push_ok = req_fire && (cmd == CMD_PUSH) && !ovf;

   always_comb begin
      pos_in = cur_pos;
      hd_in  = cur_hd;
      lf_in  = cur_lf;
      up_in  = cur_up;
      lvl_in = cur_lvl;
      case (cmd)
         CMD_ROTATE: begin
            case (pair)
               PAIR_HL: begin
                  hd_in = na;
                  lf_in = nb;
               end
               PAIR_HU: begin
                  hd_in = na;
                  up_in = nb;
               end
               default: begin
                  lf_in = na;
                  up_in = nb;
               end
            endcase
         end
         CMD_TURN: begin
            for (int i = 0; i < 3; i++) begin
               hd_in[i] = neg_dir(cur_hd[i]);
               lf_in[i] = neg_dir(cur_lf[i]);
            end
         end
         CMD_PUSH: begin
            if (!ovf) begin
               lvl_in = cur_lvl + LVL_W'(1);
            end
         end
         CMD_POP: begin
            if (!unf) begin
               lvl_in = cur_lvl - LVL_W'(1);
               for (int i = 0; i < 3; i++) begin
                  pos_in[i] = top_entry[i * POS_W +: POS_W];
                  hd_in[i]  = top_entry[3 * POS_W + i * DIR_W +: DIR_W];
                  lf_in[i]  = top_entry[3 * POS_W + AXIS_W + i * DIR_W +: DIR_W];
                  up_in[i]  = top_entry[3 * POS_W + 2*AXIS_W + i * DIR_W +: DIR_W];
               end
            end
         end
         default: begin
            pos_in = mv_pos;
         end
      endcase

      res_valid  = ovf || unf || draws;
      res_status = ovf ? ST_OVERFLOW : (unf ? ST_UNDERFLOW : ST_DRAWN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= '0;
            hd_ff[i]  <= (i == 0) ? DIR_ONE : '0;
            lf_ff[i]  <= (i == 1) ? DIR_ONE : '0;
            up_ff[i]  <= (i == 2) ? DIR_ONE : '0;
         end
         lvl_ff <= '0;
         byp_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            pos_ff <= pos_in;
            hd_ff  <= hd_in;
            lf_ff  <= lf_in;
            up_ff  <= up_in;
            lvl_ff <= lvl_in;
         end
         byp_ff <= push_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         byp_data_ff <= wr_entry;
      end
   end

   // ------------------------------------------------------------------------------------------
   // Result register.
   // ------------------------------------------------------------------------------------------
   status_type              st_ff;
   logic signed [POS_W-1:0] sx_ff, sy_ff, sz_ff;
   logic signed [POS_W-1:0] ex_ff, ey_ff, ez_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = res_valid;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && res_valid) begin
         st_ff <= res_status;
         if (draws) begin
            sx_ff <= cur_pos[0];
            sy_ff <= cur_pos[1];
            sz_ff <= cur_pos[2];
            ex_ff <= mv_pos[0];
            ey_ff <= mv_pos[1];
            ez_ff <= mv_pos[2];
         end else begin
            sx_ff <= '0;
            sy_ff <= '0;
            sz_ff <= '0;
            ex_ff <= '0;
            ey_ff <= '0;
            ez_ff <= '0;
         end
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.status  = st_ff;
   assign rsp_if.start_x = sx_ff;
   assign rsp_if.start_y = sy_ff;
   assign rsp_if.start_z = sz_ff;
   assign rsp_if.end_x   = ex_ff;
   assign rsp_if.end_y   = ey_ff;
   assign rsp_if.end_z   = ez_ff;

   // ------------------------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------------------------
   `LTTI_ASSERT_IMP(a_level_bound, clock, reset, 1'b1, lvl_ff <= LVL_FULL,
      "stack level beyond the stack depth")

   `LTTI_ASSERT_NXT(a_push_level, clock, reset, push_ok,
      lvl_ff == LVL_W'($past(cur_lvl) + LVL_W'(1)), "successful push did not raise the level")

   `LTTI_ASSERT_NXT(a_overflow_report, clock, reset, req_fire && ovf,
      rsp_if.valid && (rsp_if.status == ST_OVERFLOW) && (rsp_if.end_x == '0),
      "overflow not reported with zero coordinates")

   `LTTI_ASSERT_IMP(a_stall_blocks, clock, reset, rsp_valid_ff && !rsp_if.ready,
      !req_if.ready, "symbol taken while a stalled result fills the register")

endmodule

// ===== verif/lsystem_3d_turtle_interpreter_unit_tb.sv =====
// Testbench of the 3D turtle interpreter: symbol streams checked against a turtle predictor.
`timescale 1ns / 1ps

module lsystem_3d_turtle_interpreter_unit_tb
   import ltti_pkg::*;
();

   // Direction components are Q1.FRAC_BITS, so they carry two integer bits including sign.
   localparam int unsigned DIR_W      = LTTI_FRAC_BITS + 2;
   localparam longint      DIR_HIGH   = (longint'(1) << (DIR_W - 1)) - 1;
   localparam longint      DIR_LOW    = -(longint'(1) << (DIR_W - 1));
   localparam longint      POS_HIGH   = (longint'(1) << (POS_W - 1)) - 1;
   localparam longint      POS_LOW    = -(longint'(1) << (POS_W - 1));
   localparam longint      HALF_LSB   = longint'(1) << (LTTI_FRAC_BITS - 1);

   // Rows of the axis matrix held by the predictor.
   localparam int AX_HEADING = 0;
   localparam int AX_LEFT    = 1;
   localparam int AX_UP      = 2;

   localparam int CLOCK_PERIOD   = 10;
   localparam int RESET_CYCLES   = 12;
   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 400;

   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 240;
   localparam int PRESSURE_PHASE  = 4;

   // Idling percentages used by the phases.
   localparam int BUSY_IDLE = 55;
   localparam int BOTH_IDLE = 20;

   // A plain move symbol that draws once its mask bit is set.
   localparam logic [SYM_W-1:0] SYM_FORWARD = 8'h46;

   localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(65536);
   localparam logic signed [COEF_W-1:0] COEF_NEG = -COEF_W'(65536);

   localparam logic [SYM_W-1:0] TURN_SYMBOLS [6] = '{SYM_PLUS, SYM_MINUS, SYM_PITCH_UP,
                                                     SYM_PITCH_DOWN, SYM_ROLL_LEFT,
                                                     SYM_ROLL_RIGHT};

   typedef logic signed [POS_W-1:0] coord_type;
   typedef logic signed [DIR_W-1:0] dir_type;

   localparam dir_type DIR_ONE = dir_type'(longint'(1) << LTTI_FRAC_BITS);

   // Whole turtle: position and the heading, left and up axes as matrix rows.
   typedef struct {
      coord_type pos [3];
      dir_type   vec [3][3];
   } turtle_type;

   typedef struct {
      status_type status;
      coord_type  start_pt [3];
      coord_type  end_pt [3];
   } segment_type;

   // The scoreboard keeps its own turtle, stack and register copies. Every accepted
   // symbol is played on that turtle, and any segment or stack error it causes is queued
   // until the block hands over the matching result.
   class turtle_scoreboard_type;
      longint            cos_c;
      longint            sin_c;
      logic [MASK_W-1:0] draw_mask;
      turtle_type        cur;
      turtle_type        saved [LTTI_STACK_DEPTH];
      int                level;
      segment_type       segments_due [$];
      int                mismatches;

      function new();
         cos_c      = COS_RESET;
         sin_c      = SIN_RESET;
         draw_mask  = '0;
         mismatches = 0;
         home();
      endfunction

      function void home();
         int i;
         int j;
         for (i = 0; i < 3; i++) begin
            cur.pos[i] = '0;
            for (j = 0; j < 3; j++) begin
               cur.vec[i][j] = (i == j) ? DIR_ONE : '0;
            end
         end
         level = 0;
      endfunction

      function void set_reg(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
         dir_type coef;
         coef = value[COEF_W-1:0];
         case (idx)
            REG_COS_ANGLE: cos_c = coef;
            REG_SIN_ANGLE: sin_c = coef;
            REG_DRAW_MASK: draw_mask = value[MASK_W-1:0];
            default: ;
         endcase
      endfunction

      function dir_type clamp_dir(longint v);
         if (v > DIR_HIGH) v = DIR_HIGH;
         if (v < DIR_LOW) v = DIR_LOW;
         return dir_type'(v);
      endfunction

      function coord_type clamp_pos(longint v);
         if (v > POS_HIGH) v = POS_HIGH;
         if (v < POS_LOW) v = POS_LOW;
         return coord_type'(v);
      endfunction

      // Round to nearest with ties upward: add half an LSB, then floor by arithmetic shift.
      function dir_type round_dir(longint acc);
         return clamp_dir((acc + HALF_LSB) >>> LTTI_FRAC_BITS);
      endfunction

      // Turns the axis pair (A,B) by the angle whose cosine and sine are given.
      function void turn(int ia, int ib, longint c, longint s);
         longint a;
         longint b;
         int     i;
         for (i = 0; i < 3; i++) begin
            a = cur.vec[ia][i];
            b = cur.vec[ib][i];
            cur.vec[ia][i] = round_dir(a * c + b * s);
            cur.vec[ib][i] = round_dir(b * c - a * s);
         end
      endfunction

      // Appends a result to the tail of the outstanding list.
      function void queue_result(segment_type seg);
         segments_due.insert(segments_due.size(), seg);
      endfunction

      function void note_symbol(logic [SYM_W-1:0] sym, logic restart_bit);
         segment_type seg;
         int          i;
         if (restart_bit) home();
         seg.status = ST_DRAWN;
         for (i = 0; i < 3; i++) begin
            seg.start_pt[i] = '0;
            seg.end_pt[i]   = '0;
         end
         case (sym)
            SYM_PLUS:       turn(AX_HEADING, AX_LEFT, cos_c, sin_c);
            SYM_MINUS:      turn(AX_HEADING, AX_LEFT, cos_c, -sin_c);
            SYM_PITCH_UP:   turn(AX_HEADING, AX_UP, cos_c, sin_c);
            SYM_PITCH_DOWN: turn(AX_HEADING, AX_UP, cos_c, -sin_c);
            SYM_ROLL_LEFT:  turn(AX_LEFT, AX_UP, cos_c, -sin_c);
            SYM_ROLL_RIGHT: turn(AX_LEFT, AX_UP, cos_c, sin_c);
            SYM_TURN_AROUND: begin
               for (i = 0; i < 3; i++) begin
                  cur.vec[AX_HEADING][i] = clamp_dir(-longint'(cur.vec[AX_HEADING][i]));
                  cur.vec[AX_LEFT][i]    = clamp_dir(-longint'(cur.vec[AX_LEFT][i]));
               end
            end
            SYM_PUSH: begin
               if (level >= int'(LTTI_STACK_DEPTH)) begin
                  seg.status = ST_OVERFLOW;
                  queue_result(seg);
               end else begin
                  saved[level] = cur;
                  level++;
               end
            end
            SYM_POP: begin
               if (level == 0) begin
                  seg.status = ST_UNDERFLOW;
                  queue_result(seg);
               end else begin
                  level--;
                  cur = saved[level];
               end
            end
            default: begin
               for (i = 0; i < 3; i++) begin
                  seg.start_pt[i] = cur.pos[i];
                  cur.pos[i] = clamp_pos(longint'(cur.pos[i]) +
                                         longint'(cur.vec[AX_HEADING][i]));
                  seg.end_pt[i] = cur.pos[i];
               end
               if (sym[7:6] == DRAW_BANK && draw_mask[sym[5:0]]) queue_result(seg);
            end
         endcase
      endfunction

      function int pending();
         return segments_due.size();
      endfunction

      function string show(segment_type seg);
         return $sformatf("%s (%0d,%0d,%0d)->(%0d,%0d,%0d)", seg.status.name(),
                          seg.start_pt[0], seg.start_pt[1], seg.start_pt[2],
                          seg.end_pt[0], seg.end_pt[1], seg.end_pt[2]);
      endfunction

      task report(string what);
         mismatches++;
         $display("%0t mismatch: %s", $time, what);
      endtask

      task check_segment(segment_type got);
         segment_type want;
         bit          differs;
         int          i;
         if (segments_due.size() == 0) begin
            report($sformatf("result %s with nothing outstanding", show(got)));
         end else begin
            want    = segments_due.pop_front();
            differs = (got.status !== want.status);
            for (i = 0; i < 3; i++) begin
               if (got.start_pt[i] !== want.start_pt[i] || got.end_pt[i] !== want.end_pt[i])
                  differs = 1'b1;
            end
            if (differs) report($sformatf("result %s, expected %s", show(got), show(want)));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   ltti_req_if req_bus ();
   ltti_rsp_if rsp_bus ();

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   turtle_scoreboard_type sb = new();

   // Idling controls, changed by the main sequence between phases only.
   int gap_pct   = 0;
   int stall_pct = 0;

   // The main sequence raises hold_requests; the receiver alone counts out the hold.
   int hold_requests = 0;
   int holds_served  = 0;
   int hold_left     = 0;

   int          items_sent   = 0;
   int          quiet_cycles = 0;
   segment_type seen;

   lsystem_3d_turtle_interpreter_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Receiver side. Outside a hold it stalls at the phase's rate. A hold keeps ready low
   // for a long stretch so that the result register stays full and the block has to
   // push back on the symbol channel.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= HOLD_CYCLES;
         holds_served  <= holds_served + 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Both channels are sampled here, at the edge of each transfer. A symbol is noted
   // before any result of the same edge is checked, although with a registered result
   // path a symbol can never be answered at the edge that accepts it. The watchdog
   // counts the edges at which neither channel moves a transfer.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) sb.note_symbol(req_bus.symbol, req_bus.restart);
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.status      = rsp_bus.status;
            seen.start_pt[0] = rsp_bus.start_x;
            seen.start_pt[1] = rsp_bus.start_y;
            seen.start_pt[2] = rsp_bus.start_z;
            seen.end_pt[0]   = rsp_bus.end_x;
            seen.end_pt[1]   = rsp_bus.end_y;
            seen.end_pt[2]   = rsp_bus.end_z;
            sb.check_segment(seen);
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Offers one symbol, with a random number of idle cycles first at the phase's rate,
   // and returns at the edge that accepts it. Valid is left high, so back-to-back symbols
   // keep it up without a glitch; the next call or drain decides what it does next.
   task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic restart_bit);
      while ($urandom_range(99) < gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.symbol  <= sym;
      req_bus.restart <= restart_bit;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
   endtask

   // Stops offering symbols and waits until every outstanding result has arrived. The
   // first edge lets the monitor note a symbol accepted at the edge this was called on.
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write: a setup cycle, then an access cycle held until pready. Select
   // is left high so that a following write can go straight into its setup cycle.
   task automatic csr_write(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx) << REG_LSB;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.set_reg(idx, value);
   endtask

   // Registers change only with the block idle. The angle registers are written
   // sign-extended to the full data width.
   task automatic configure(input logic signed [COEF_W-1:0] c,
                            input logic signed [COEF_W-1:0] s,
                            input logic [MASK_W-1:0] mask);
      drain();
      csr_write(REG_COS_ANGLE, CSR_DATA_W'(c));
      csr_write(REG_SIN_ANGLE, CSR_DATA_W'(s));
      csr_write(REG_DRAW_MASK, CSR_DATA_W'(mask));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic logic [SYM_W-1:0] pick_turn();
      return TURN_SYMBOLS[$urandom_range(5)];
   endfunction

   // A deep nest of pushes, sprinkled with moves, that is sure to run into the full
   // stack, followed by enough pops to empty it and always pop at least once too often.
   task automatic stack_burst();
      int depth_goal;
      int k;
      depth_goal = $urandom_range(LTTI_STACK_DEPTH + 3, LTTI_STACK_DEPTH + 1);
      for (k = 0; k < depth_goal; k++) begin
         send_symbol(SYM_PUSH, 1'b0);
         if ($urandom_range(3) == 0) send_symbol(SYM_W'($urandom_range(127, 64)), 1'b0);
      end
      for (k = 0; k < depth_goal + int'($urandom_range(2)); k++) begin
         send_symbol(SYM_POP, 1'b0);
         if ($urandom_range(3) == 0) send_symbol(pick_turn(), 1'b0);
      end
   endtask

   // Mostly the shape of a real interpreted string: turns, branches in brackets and
   // moves in the drawing range. A few arbitrary bytes and restarts are mixed in.
   task automatic run_random(input int count);
      int               target;
      int               pick;
      logic [SYM_W-1:0] sym;
      target = items_sent + count;
      while (items_sent < target) begin
         pick = $urandom_range(999);
         if (pick < 4) begin
            stack_burst();
         end else begin
            if (pick < 320) sym = pick_turn();
            else if (pick < 360) sym = SYM_TURN_AROUND;
            else if (pick < 480) sym = SYM_PUSH;
            else if (pick < 600) sym = SYM_POP;
            else if (pick < 930) sym = SYM_W'($urandom_range(127, 64));
            else sym = SYM_W'($urandom);
            send_symbol(sym, $urandom_range(99) < 3);
         end
      end
   endtask

   initial begin
      int                       phase;
      logic signed [COEF_W-1:0] c;
      logic signed [COEF_W-1:0] s;
      logic [MASK_W-1:0]        mask;

      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.symbol  = '0;
      req_bus.restart = 1'b0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // With the register values from reset a move draws nothing and a turn is the
      // identity rotation.
      send_symbol(SYM_FORWARD, 1'b0);
      send_symbol(SYM_PLUS, 1'b0);

      // An angle with cosine and sine both one grows the axes by root two per turn, so
      // two turns in a row drive components onto the direction rails, and the turn
      // around then has to negate the most negative value.
      configure(COEF_ONE, COEF_ONE, '1);
      send_symbol(SYM_FORWARD, 1'b0);
      send_symbol(SYM_PLUS, 1'b0);
      send_symbol(SYM_PLUS, 1'b0);
      send_symbol(SYM_TURN_AROUND, 1'b0);
      send_symbol(SYM_MINUS, 1'b0);
      send_symbol(SYM_PITCH_UP, 1'b0);
      send_symbol(SYM_PITCH_DOWN, 1'b0);
      send_symbol(SYM_ROLL_LEFT, 1'b0);
      send_symbol(SYM_ROLL_RIGHT, 1'b0);
      // Popping an empty stack, then a branch that is restored on the pop.
      send_symbol(SYM_POP, 1'b0);
      send_symbol(SYM_PUSH, 1'b0);
      send_symbol(SYM_FORWARD, 1'b0);
      send_symbol(SYM_POP, 1'b0);
      // The edges of the drawing range and bytes on either side of it.
      send_symbol(8'h00, 1'b0);
      send_symbol(8'hff, 1'b0);
      send_symbol(8'h40, 1'b0);
      send_symbol(8'h7f, 1'b0);
      send_symbol(8'h3f, 1'b0);
      send_symbol(8'h80, 1'b0);
      // A restart homes the turtle and empties the stack before its own symbol.
      send_symbol(SYM_PUSH, 1'b0);
      send_symbol(SYM_FORWARD, 1'b1);
      send_symbol(SYM_POP, 1'b1);

      // Random phases, each with its own angle, mask and idling pattern.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         c    = COEF_W'(int'($urandom_range(131072)) - 65536);
         s    = COEF_W'(int'($urandom_range(131072)) - 65536);
         mask = {$urandom, $urandom};
         case (phase)
            0: begin
               c    = COEF_W'(59040);
               s    = COEF_W'(28440);
               mask = '1;
            end
            1: begin
               c = COEF_NEG;
               s = '0;
            end
            2: begin
               c = '0;
               s = COEF_ONE;
            end
            3: begin
               c    = '0;
               s    = COEF_NEG;
               mask = '1;
            end
            4: mask = '1;
            5: begin
               c = COEF_ONE;
               s = COEF_NEG;
            end
            7: begin
               c    = COEF_NEG;
               s    = COEF_NEG;
               mask = '1;
            end
            default: ;
         endcase
         configure(c, s, mask);
         case (phase % 4)
            0: begin
               gap_pct   = 0;
               stall_pct = 0;
            end
            1: begin
               gap_pct   = BUSY_IDLE;
               stall_pct = 0;
            end
            2: begin
               gap_pct   = 0;
               stall_pct = BUSY_IDLE;
            end
            default: begin
               gap_pct   = BOTH_IDLE;
               stall_pct = BOTH_IDLE;
            end
         endcase
         // The sender runs flat out into a long receiver hold.
         if (phase == PRESSURE_PHASE) hold_requests++;
         run_random(ITEMS_PER_PHASE);
      end

      drain();
      if (sb.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ltti_pkg.sv
rtl/ltti_req_if.sv
rtl/ltti_rsp_if.sv
rtl/ltti_ram.sv
rtl/lsystem_3d_turtle_interpreter_unit.sv
verif/lsystem_3d_turtle_interpreter_unit_tb.sv
